/* hdl/dq_pkg.sv */
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned STAT_W = 2;

  // Largest positive word, returned for empty or invalid reads.
  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FRONT      = 3'd4,
    CMD_BACK       = 3'd5,
    CMD_READ_AT    = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ADDR_FRONT,
    ADDR_PREV,
    ADDR_TAIL,
    ADDR_LAST,
    ADDR_POS
  } addr_sel_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_DEC,
    PTR_ZERO
  } ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_e;

  typedef enum logic [1:0] {
    DK_ZERO,
    DK_MAX,
    DK_MEM
  } data_kind_e;

  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    addr_sel_e  addr_sel;
    ptr_op_e    ptr_op;
    cnt_op_e    cnt_op;
    logic       load_rsp;
    status_e    status;
    data_kind_e data_kind;
  } dq_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_of_range;
  } dq_flags_t;

endpackage

/* hdl/dq_cmd_if.sv */
`timescale 1ns / 1ps

interface dq_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [dq_pkg::CMD_W-1:0]          command;
  logic signed [dq_pkg::DATA_W-1:0]  data_in;
  logic [dq_pkg::POS_W-1:0]          position;

  modport source (output valid, output command, output data_in, output position,
                  input ready);
  modport sink (input valid, input command, input data_in, input position,
                output ready);
endinterface

/* hdl/dq_rsp_if.sv */
`timescale 1ns / 1ps

interface dq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::DATA_W-1:0]  data_out;
  logic [dq_pkg::CNT_W-1:0]          count;
  logic [dq_pkg::STAT_W-1:0]         status;

  modport source (output valid, output data_out, output count, output status,
                  input ready);
  modport sink (input valid, input data_out, input count, input status,
                output ready);
endinterface

/* hdl/dq_ctrl.sv */
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  logic [dq_pkg::CMD_W-1:0]  command_i,
  output logic                      cmd_ready_o,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  input  dq_pkg::dq_flags_t         flags_i,
  output dq_pkg::dq_ctrl_t          ctrl_o
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   accept;
  cmd_e   cmd;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign cmd         = cmd_e'(command_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q     <= S_RESP;
            rsp_valid_q <= 1'b1;
          end
        end
        S_RESP: begin
          if (rsp_ready_i) begin
            state_q     <= S_IDLE;
            rsp_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          rsp_valid_q <= 1'b0;
        end
      endcase
    end
  end

  // Command decode. Side effects are only issued on the transfer cycle.
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.addr_sel  = ADDR_FRONT;
    ctrl_o.ptr_op    = PTR_HOLD;
    ctrl_o.cnt_op    = CNT_HOLD;
    ctrl_o.status    = ST_OK;
    ctrl_o.data_kind = DK_ZERO;
    ctrl_o.load_rsp  = accept;
    if (accept) begin
      unique case (cmd) inside
        CMD_PUSH_FRONT: begin
          if (flags_i.full) begin
            ctrl_o.status = ST_FULL;
          end else begin
            ctrl_o.wr_en    = 1'b1;
            ctrl_o.addr_sel = ADDR_PREV;
            ctrl_o.ptr_op   = PTR_DEC;
            ctrl_o.cnt_op   = CNT_INC;
          end
        end
        CMD_PUSH_BACK: begin
          if (flags_i.full) begin
            ctrl_o.status = ST_FULL;
          end else begin
            ctrl_o.wr_en    = 1'b1;
            ctrl_o.addr_sel = ADDR_TAIL;
            ctrl_o.cnt_op   = CNT_INC;
          end
        end
        CMD_POP_FRONT, CMD_FRONT: begin
          if (flags_i.empty) begin
            ctrl_o.status    = ST_EMPTY;
            ctrl_o.data_kind = DK_MAX;
          end else begin
            ctrl_o.rd_en     = 1'b1;
            ctrl_o.addr_sel  = ADDR_FRONT;
            ctrl_o.data_kind = DK_MEM;
            if (cmd == CMD_POP_FRONT) begin
              ctrl_o.ptr_op = PTR_INC;
              ctrl_o.cnt_op = CNT_DEC;
            end
          end
        end
        CMD_POP_BACK, CMD_BACK: begin
          if (flags_i.empty) begin
            ctrl_o.status    = ST_EMPTY;
            ctrl_o.data_kind = DK_MAX;
          end else begin
            ctrl_o.rd_en     = 1'b1;
            ctrl_o.addr_sel  = ADDR_LAST;
            ctrl_o.data_kind = DK_MEM;
            if (cmd == CMD_POP_BACK) begin
              ctrl_o.cnt_op = CNT_DEC;
            end
          end
        end
        CMD_READ_AT: begin
          if (flags_i.empty) begin
            ctrl_o.status    = ST_EMPTY;
            ctrl_o.data_kind = DK_MAX;
          end else if (flags_i.out_of_range) begin
            ctrl_o.status    = ST_RANGE;
            ctrl_o.data_kind = DK_MAX;
          end else begin
            ctrl_o.rd_en     = 1'b1;
            ctrl_o.addr_sel  = ADDR_POS;
            ctrl_o.data_kind = DK_MEM;
          end
        end
        CMD_CLEAR: begin
          ctrl_o.ptr_op = PTR_ZERO;
          ctrl_o.cnt_op = CNT_ZERO;
        end
        default: begin
          ctrl_o.ptr_op = PTR_HOLD;
        end
      endcase
    end
  end

endmodule

/* hdl/dq_datapath.sv */
`timescale 1ns / 1ps

module dq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dq_pkg::dq_ctrl_t                  ctrl_i,
  input  logic signed [dq_pkg::DATA_W-1:0]  data_in_i,
  input  logic [dq_pkg::POS_W-1:0]          position_i,
  output dq_pkg::dq_flags_t                 flags_o,
  output logic signed [dq_pkg::DATA_W-1:0]  data_out_o,
  output logic [dq_pkg::CNT_W-1:0]          count_o,
  output logic [dq_pkg::STAT_W-1:0]         status_o
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] storage_q [DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]        ptr_q, ptr_d;
  logic [CNT_W-1:0]         count_q, count_d;
  status_e                  status_q;
  data_kind_e               kind_q;
  logic [ADDR_W-1:0]        addr;
  logic [ADDR_W-1:0]        count_lo;

  assign count_lo = count_q[ADDR_W-1:0];

  assign flags_o.empty        = (count_q == '0);
  assign flags_o.full         = (count_q == CNT_W'(DEPTH));
  assign flags_o.out_of_range = (CNT_W'(position_i) >= count_q);

  // Ring address of the entry touched by the command; wraps by truncation.
  always_comb begin
    case (ctrl_i.addr_sel)
      ADDR_FRONT: addr = ptr_q;
      ADDR_PREV:  addr = ptr_q - ADDR_W'(1);
      ADDR_TAIL:  addr = ptr_q + count_lo;
      ADDR_LAST:  addr = ptr_q + count_lo - ADDR_W'(1);
      ADDR_POS:   addr = ptr_q + ADDR_W'(position_i);
      default:    addr = ptr_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.ptr_op)
      PTR_INC:  ptr_d = ptr_q + ADDR_W'(1);
      PTR_DEC:  ptr_d = ptr_q - ADDR_W'(1);
      PTR_ZERO: ptr_d = '0;
      default:  ptr_d = ptr_q;
    endcase
    case (ctrl_i.cnt_op)
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_DEC:  count_d = count_q - CNT_W'(1);
      CNT_ZERO: count_d = '0;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      count_q <= '0;
    end else begin
      ptr_q   <= ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      storage_q[addr] <= data_in_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= storage_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_rsp) begin
      status_q <= ctrl_i.status;
      kind_q   <= ctrl_i.data_kind;
    end
  end

  always_comb begin
    case (kind_q)
      DK_MEM:  data_out_o = rd_data_q;
      DK_MAX:  data_out_o = INT_MAX;
      default: data_out_o = '0;
    endcase
  end

  assign count_o  = count_q;
  assign status_o = status_q;

endmodule

/* hdl/double_ended_queue_core.sv */
`timescale 1ns / 1ps
// Bounded double-ended queue of 64 signed 32-bit words in a circular buffer.
// The result is valid in the cycle after the command transfer.
// A new command waits for the last result to be transferred; the single-port
// storage read is registered and the result register holds one result.
// Reset: front pointer and count clear to zero; storage is not cleared.

module double_ended_queue_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_cmd_if.sink   cmd_i,
  dq_rsp_if.source rsp_o
);
  import dq_pkg::*;

  dq_ctrl_t  ctrl;
  dq_flags_t flags;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .command_i   (cmd_i.command),
    .cmd_ready_o (cmd_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .flags_i     (flags),
    .ctrl_o      (ctrl)
  );

  dq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .data_in_i  (cmd_i.data_in),
    .position_i (cmd_i.position),
    .flags_o    (flags),
    .data_out_o (rsp_o.data_out),
    .count_o    (rsp_o.count),
    .status_o   (rsp_o.status)
  );

`ifndef SYNTHESIS
  a_rsp_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> rsp_o.valid)
    else $error("no result after command transfer");

  a_no_cmd_while_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !cmd_i.ready)
    else $error("command taken while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.count <= CNT_W'(DEPTH)))
    else $error("count exceeds depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_FULL)) |-> (rsp_o.count == CNT_W'(DEPTH)))
    else $error("full status with a non-full queue");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_EMPTY))
      |-> ((rsp_o.count == '0) && (rsp_o.data_out == INT_MAX)))
    else $error("empty status inconsistent with count or data");
`endif

endmodule
